/* rtl/exp_golomb_ue_decoder_defines.svh */
// Assertion macros used by the back end of the Exp-Golomb decoder.
`ifndef EXP_GOLOMB_UE_DECODER_DEFINES_SVH
`define EXP_GOLOMB_UE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define EGD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define EGD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/egd_pkg.sv */
// Package with the types and constants of the Exp-Golomb ue(v) decoder.
`timescale 1ns / 1ps
`default_nettype none

package egd_pkg;

	localparam int MAX_PREFIX  = 31;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} egd_in_t;

	typedef struct packed {
		logic [31:0] code_value;
		logic        overflow;
		logic        last;
	} egd_out_t;

	// One queued byte with its front-end classification.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
		logic       all_zero;
	} egd_entry_t;

	typedef struct packed {
		logic       valid;
		egd_entry_t entry;
	} egd_head_t;

	typedef struct packed {
		logic        in_suffix;
		logic [5:0]  zero_run;
		logic [5:0]  bits_left;
		logic [31:0] accumulator;
	} egd_code_t;

	typedef struct packed {
		logic     valid;
		egd_out_t res;
	} egd_pend_t;

endpackage

`default_nettype wire

/* rtl/exp_golomb_ue_decoder.sv */
// Top level of the unsigned Exp-Golomb ue(v) decoder.
`timescale 1ns / 1ps
`default_nettype none

// Bytes enter a four-entry queue, where each is tagged when it holds no one bit. The back
// end decodes one bit per cycle while the pending slot can take a result; a tagged byte
// that can neither finish nor overflow the current zero prefix skips the bit engine and
// is consumed when it is loaded. Loading the next byte overlaps the last bit of the
// current one, so the engine does not idle between the bytes of a steady stream while
// results are taken. Each completed code waits in a pending register until the next code
// or the end of its byte shows whether it is the last result of that byte, then moves to
// the output register.
module exp_golomb_ue_decoder
	import egd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    byte_valid,
	output logic         byte_ready,
	input  wire egd_in_t byte_item,
	output logic         res_valid,
	input  wire logic    res_ready,
	output egd_out_t     res_item
);

	egd_head_t head;
	logic      head_pop;

	egd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.head       (head),
		.head_pop   (head_pop)
	);

	egd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_pop  (head_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

/* rtl/egd_front.sv */
// Front end: accepts bytes, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
`default_nettype none

module egd_front
	import egd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_ready,
	input  wire egd_in_t   byte_item,
	output egd_head_t      head,
	input  wire logic      head_pop
);

	egd_entry_t            entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  push;
	logic                  pop;

	assign byte_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign push       = byte_valid && byte_ready;
	assign pop        = head_pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q].data_byte <= byte_item.data_byte;
			entries_q[wr_ptr_q].restart   <= byte_item.restart;
			entries_q[wr_ptr_q].all_zero  <= (byte_item.data_byte == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/egd_back.sv */
// Back end: bit-serial ue(v) decode engine with a pending result and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "exp_golomb_ue_decoder_defines.svh"

module egd_back
	import egd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire egd_head_t head,
	output logic           head_pop,
	output logic           res_valid,
	input  wire logic      res_ready,
	output egd_out_t       res_item
);

	egd_code_t   code_q;
	logic [7:0]  byte_q;
	logic [2:0]  bit_idx_q;
	logic        busy_q;
	egd_pend_t   pend_q;
	logic        out_valid_q;
	egd_out_t    out_q;

	logic        o_free;
	logic        step;
	logic        bit_in;
	logic        is_end;
	logic        emit;
	egd_out_t    emit_res;
	egd_code_t   code_step;
	egd_code_t   code_d;
	logic        fast;
	logic        p_move;
	logic [31:0] acc_shift;
	logic [5:0]  run_inc;
	logic [5:0]  left_dec;

	assign o_free = !out_valid_q || res_ready;
	// A bit is only decoded when the pending slot can make room for a new result.
	assign step   = busy_q && (!pend_q.valid || o_free);
	assign bit_in = byte_q[bit_idx_q];
	assign is_end = step && (bit_idx_q == 3'd0);

	assign acc_shift = {code_q.accumulator[30:0], bit_in};
	assign run_inc   = code_q.zero_run + 6'd1;
	assign left_dec  = code_q.bits_left - 6'd1;

	// One bit of the ue(v) grammar.
	always_comb begin
		code_step           = code_q;
		emit                = 1'b0;
		emit_res.code_value = '0;
		emit_res.overflow   = 1'b0;
		emit_res.last       = is_end;
		if (!code_q.in_suffix) begin
			if (!bit_in) begin
				if (run_inc > 6'(MAX_PREFIX)) begin
					emit              = 1'b1;
					emit_res.overflow = 1'b1;
					code_step         = '0;
				end else begin
					code_step.zero_run = run_inc;
				end
			end else if (code_q.zero_run == 6'd0) begin
				emit      = 1'b1;
				code_step = '0;
			end else begin
				code_step.in_suffix   = 1'b1;
				code_step.bits_left   = code_q.zero_run;
				code_step.accumulator = '0;
			end
		end else begin
			code_step.accumulator = acc_shift;
			code_step.bits_left   = left_dec;
			if (left_dec == 6'd0) begin
				emit                = 1'b1;
				emit_res.code_value = acc_shift
					+ ((32'd1 << code_q.zero_run) - 32'd1);
				code_step           = '0;
			end
		end
	end

	assign head_pop = head.valid && (!busy_q || is_end);

	// Code state after this cycle's bit and an optional byte load.
	always_comb begin
		code_d = step ? code_step : code_q;
		fast   = 1'b0;
		if (head_pop) begin
			if (head.entry.restart) begin
				code_d = '0;
			end
			// An all-zero byte that cannot finish or overflow a prefix passes at once.
			if (head.entry.all_zero && !code_d.in_suffix
					&& ({1'b0, code_d.zero_run} + 7'd8 <= 7'(MAX_PREFIX))) begin
				fast            = 1'b1;
				code_d.zero_run = code_d.zero_run + 6'd8;
			end
		end
	end

	assign p_move = pend_q.valid && o_free && (pend_q.res.last || (step && emit));

	always_ff @(posedge clk) begin
		if (head_pop) begin
			byte_q <= head.entry.data_byte;
		end
		if (p_move) begin
			out_q <= pend_q.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q      <= '0;
			bit_idx_q   <= '0;
			busy_q      <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			code_q <= code_d;
			if (head_pop) begin
				bit_idx_q <= 3'd7;
				busy_q    <= !fast;
			end else begin
				if (step) begin
					bit_idx_q <= bit_idx_q - 3'd1;
				end
				if (is_end) begin
					busy_q <= 1'b0;
				end
			end

			if (step && emit) begin
				pend_q.valid <= 1'b1;
				pend_q.res   <= emit_res;
			end else if (p_move) begin
				pend_q.valid <= 1'b0;
			end else if (is_end && pend_q.valid) begin
				pend_q.res.last <= 1'b1;
			end

			if (p_move) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	`EGD_ASSERT_IMP(a_ovf_zero, out_valid_q && out_q.overflow, out_q.code_value == 32'd0,
		"overflow result with nonzero value")
	`EGD_ASSERT_IMP(a_suffix_len, code_q.in_suffix,
		(code_q.bits_left != 6'd0) && (code_q.bits_left <= code_q.zero_run),
		"suffix count out of range")
	`EGD_ASSERT_IMP(a_run_max, 1'b1, code_q.zero_run <= 6'(MAX_PREFIX),
		"zero run beyond maximum prefix")
	`EGD_ASSERT_NXT(a_forward, step && emit && pend_q.valid, out_valid_q && pend_q.valid,
		"pending result lost on new emission")

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the unsigned Exp-Golomb ue(v) decoder.
`timescale 1ns / 1ps

module testbench
	import egd_pkg::*;
();

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_BYTES  = 105;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_ready;
	egd_in_t  byte_item = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	egd_out_t res_item;

	exp_golomb_ue_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the byte stream has left it.
	logic        in_info;
	logic [5:0]  pfx_len;
	logic [5:0]  info_left;
	logic [31:0] info_bits;

	egd_out_t expected_codes[$];
	int       errors = 0;
	int       cycles = 0;
	int       burst_left = 0;
	int       ready_mode = 0;

	task automatic clear_code_state();
		in_info   = 1'b0;
		pfx_len   = '0;
		info_left = '0;
		info_bits = '0;
	endtask

	// Walks the byte bit by bit and queues every code that it completes.
	task automatic decode_byte(input egd_in_t it);
		egd_out_t    found[$];
		egd_out_t    r;
		logic        b;
		logic [63:0] v;
		if (it.restart)
			clear_code_state();
		for (int i = 7; i >= 0; i--) begin
			b = it.data_byte[i];
			r = '0;
			if (!in_info) begin
				if (!b) begin
					pfx_len = pfx_len + 6'd1;
					if (pfx_len > MAX_PREFIX) begin
						r.overflow = 1'b1;
						found.push_back(r);
						clear_code_state();
					end
				end else if (pfx_len == 0) begin
					found.push_back(r);
					clear_code_state();
				end else begin
					in_info   = 1'b1;
					info_left = pfx_len;
					info_bits = '0;
				end
			end else begin
				info_bits = {info_bits[30:0], b};
				info_left = info_left - 6'd1;
				if (info_left == 0) begin
					v = 64'(info_bits) + ((64'd1 << pfx_len) - 64'd1);
					r.code_value = v[31:0];
					found.push_back(r);
					clear_code_state();
				end
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[k])
			expected_codes.push_back(found[k]);
	endtask

	// Must be called at a rising edge. Valid stays high across a burst.
	task automatic send_byte(input logic [7:0] data, input logic rs);
		egd_in_t it;
		int      gap;
		it.data_byte = data;
		it.restart   = rs;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do
			@(posedge clk);
		while (!byte_ready);
		decode_byte(it);
		burst_left--;
	endtask

	// Stops sending and waits until every expected result has been taken.
	task automatic drain();
		byte_valid <= 1'b0;
		burst_left = 0;
		while (expected_codes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_zero_codes();
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		drain();
	endtask

	task automatic test_cross_byte_codes();
		// Seven zeros and a one, then the seven information bits in the next byte.
		send_byte(8'h01, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b0);
		drain();
	endtask

	task automatic test_longest_prefix();
		// Thirty-one zeros and a one, then thirty-one ones: the largest value.
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFE, 1'b0);
		// A prefix one zero too long raises overflow and decoding resumes.
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		drain();
	endtask

	task automatic test_restart();
		// A partial prefix and a partial suffix are both dropped without a result.
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h08, 1'b1);
		send_byte(8'hFF, 1'b1);
		drain();
	endtask

	// Mostly well-formed codes with random content, plus noise and restarts.
	task automatic test_random_stream();
		bit          stream[$];
		logic [7:0]  data;
		logic [31:0] info;
		int          pick;
		int          n;
		for (int sent = 0; sent < RANDOM_BYTES; sent++) begin
			while (stream.size() < 8) begin
				pick = $urandom_range(0, 99);
				if (pick < 97) begin
					if (pick < 60)
						n = $urandom_range(0, 3);
					else if (pick < 90)
						n = $urandom_range(4, 12);
					else
						n = $urandom_range(13, 31);
					info = $urandom;
					repeat (n) stream.push_back(1'b0);
					stream.push_back(1'b1);
					for (int k = n - 1; k >= 0; k--)
						stream.push_back(info[k]);
				end else begin
					repeat ($urandom_range(32, 40)) stream.push_back(1'b0);
				end
			end
			for (int k = 7; k >= 0; k--)
				data[k] = stream.pop_front();
			if ($urandom_range(0, 9) == 0)
				data = 8'($urandom_range(0, 255));
			send_byte(data, $urandom_range(0, 19) == 0);
		end
		drain();
	endtask

	// The receiver switches among four res_ready patterns, picked at random.
	always @(posedge clk) begin
		if (cycles % 100 == 0)
			ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= 1'($urandom_range(0, 1));
			2: res_ready <= (cycles % 8 == 0);
			default: res_ready <= ($urandom_range(0, 15) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result value=%0d overflow=%0b last=%0b",
					$time, res_item.code_value, res_item.overflow, res_item.last);
				errors++;
			end else begin
				if (res_item.code_value !== expected_codes[0].code_value) begin
					$display("%0t: code_value expected %0d, got %0d", $time,
						expected_codes[0].code_value, res_item.code_value);
					errors++;
				end
				if (res_item.overflow !== expected_codes[0].overflow) begin
					$display("%0t: overflow expected %0b, got %0b", $time,
						expected_codes[0].overflow, res_item.overflow);
					errors++;
				end
				if (res_item.last !== expected_codes[0].last) begin
					$display("%0t: last expected %0b, got %0b", $time,
						expected_codes[0].last, res_item.last);
					errors++;
				end
				void'(expected_codes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		clear_code_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_codes();
		test_cross_byte_codes();
		test_longest_prefix();
		test_restart();
		test_random_stream();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/egd_pkg.sv
rtl/egd_front.sv
rtl/egd_back.sv
rtl/exp_golomb_ue_decoder.sv
verif/testbench.sv
